@@ rtl/prmf_pkg.sv @@
// ----------------------------------------------------------------------------
// prmf_pkg
// Shared types and constants for the push-relabel max flow unit.
// ----------------------------------------------------------------------------
package prmf_pkg;

    localparam int IN_TDATA_W  = 24;  // edge_from, edge_to, edge_capacity
    localparam int OUT_TDATA_W = 24;  // total_flow, zero fill
    localparam int FLOW_OUT_W  = 20;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 5;

    localparam logic [CFG_INDEX_W-1:0] CFG_VERTEX_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE       = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SINK         = 2'd2;

    localparam logic [4:0] VERTEX_COUNT_RESET = 5'd16;
    localparam logic [3:0] SOURCE_RESET       = 4'd0;
    localparam logic [3:0] SINK_RESET         = 4'd15;

    localparam longint SOURCE_PRELOAD = 64'd1000000000;

    typedef enum logic [12:0] {
        ST_CLEAR = 13'b0000000000001,
        ST_LOAD  = 13'b0000000000010,
        ST_INIT  = 13'b0000000000100,
        ST_PRD   = 13'b0000000001000,
        ST_EVAL  = 13'b0000000010000,
        ST_WR2   = 13'b0000000100000,
        ST_POP   = 13'b0000001000000,
        ST_DCHK  = 13'b0000010000000,
        ST_LRD   = 13'b0000100000000,
        ST_LEV   = 13'b0001000000000,
        ST_SRD   = 13'b0010000000000,
        ST_SEV   = 13'b0100000000000,
        ST_OUT   = 13'b1000000000000
    } state_t;

endpackage

@@ rtl/push_relabel_max_flow_unit.sv @@
// ----------------------------------------------------------------------------
// push_relabel_max_flow_unit
// FIFO push-relabel max flow over a capacity matrix loaded edge by edge.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one directed edge per transfer; tlast marks the final edge
//   and starts the flow run. Edges load at one per cycle while s_axis_tready
//   is high. An edge naming a vertex at or above the vertex count is dropped.
//   m_axis carries one result per run: total flow in tdata, error flag in
//   tuser (source equals sink or either outside the graph, flow zero).
//   cfg writes vertex_count (0), source_vertex (1), sink_vertex (2); it is
//   always ready, and must be written only while idle (the block does not enforce it).
// Run: after the last edge the run is data dependent: a vertex init pass
//   over all MAX_VERTICES entries, a read and an evaluate step per push
//   candidate plus a write step when flow moves, a read and an evaluate step
//   per lift scan step, then a sum of the sink flow over the vertices. The
//   single read port of the matrix memories sets this pace.
// Reset and clear: after reset and after every result a clearing pass over
//   all 2**(2*clog2(MAX_VERTICES)) entries (256 at the default) zeroes the
//   matrices; s_axis is not ready during it.
// Stall: the result is held in the output register until taken; no new edge
//   is accepted until then.
// ----------------------------------------------------------------------------
module push_relabel_max_flow_unit #(
    parameter int MAX_VERTICES = 16,
    parameter int CAP_BITS     = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [3:0] edge_from, [7:4] edge_to, [23:8] edge_capacity
    input  logic [prmf_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [19:0] total_flow, [23:20] zero
    output logic [prmf_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // [0] config_error
    output logic                                m_axis_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [prmf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [prmf_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import prmf_pkg::*;

    localparam int VB    = $clog2(MAX_VERTICES);
    localparam int NB    = $clog2(MAX_VERTICES + 1);
    localparam int CW    = (NB > 5) ? NB : 5;
    localparam int AW    = 2 * VB;
    localparam int DEPTH = 1 << AW;
    localparam int FW    = CAP_BITS + 1;
    localparam int DW    = CAP_BITS + 1;
    localparam int RW    = CAP_BITS + 2;
    localparam int EXA   = CAP_BITS + VB + 1;
    localparam int EXW   = (EXA > 31) ? EXA : 31;
    localparam int HW    = NB + 2;
    localparam int SW    = FW + VB + 1;
    localparam int XW    = SW + FLOW_OUT_W;
    localparam int QSW   = NB + 1;

    function automatic logic [VB-1:0] to_idx(input logic [3:0] x);
        logic [CW-1:0] w;
        w = CW'(x);
        return w[VB-1:0];
    endfunction

    // configuration
    logic [4:0] vertex_count_reg;
    logic [3:0] source_reg;
    logic [3:0] sink_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= VERTEX_COUNT_RESET;
            source_reg       <= SOURCE_RESET;
            sink_reg         <= SINK_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_VERTEX_COUNT: vertex_count_reg <= cfg_data;
                CFG_SOURCE:       source_reg       <= cfg_data[3:0];
                CFG_SINK:         sink_reg         <= cfg_data[3:0];
                default:          ;
            endcase
        end
    end

    // storage
    logic        [CAP_BITS-1:0] cap_mem  [DEPTH];
    logic signed [FW-1:0]       flow_mem [DEPTH];
    logic        [CAP_BITS-1:0] cap_rd_reg;
    logic signed [FW-1:0]       flow_rd_reg;

    logic [HW-1:0]  height_arr [MAX_VERTICES];
    logic [EXW-1:0] excess_arr [MAX_VERTICES];
    logic [NB-1:0]  ptr_arr    [MAX_VERTICES];
    logic [VB-1:0]  queue_arr  [MAX_VERTICES];

    // sequencer registers
    state_t          state_reg, state_next;
    logic [AW-1:0]   clr_reg, clr_next;
    logic [NB-1:0]   cnt_reg, cnt_next;
    logic [VB-1:0]   a_reg, a_next;
    logic [VB-1:0]   b_reg, b_next;
    logic            init_reg, init_next;
    logic [EXW-1:0]  ecur_reg, ecur_next;
    logic [HW-1:0]   hcur_reg, hcur_next;
    logic [DW-1:0]   d_reg, d_next;
    logic [HW-1:0]   low_reg, low_next;
    logic            found_reg, found_next;
    logic signed [SW-1:0] sum_reg, sum_next;
    logic [VB-1:0]   head_reg, head_next;
    logic [NB-1:0]   qcnt_reg, qcnt_next;
    logic [FLOW_OUT_W-1:0] flow_out_reg, flow_out_next;
    logic            err_out_reg, err_out_next;

    // write ports
    logic                 cap_we;
    logic [AW-1:0]        cap_wa;
    logic [CAP_BITS-1:0]  cap_wd;
    logic                 fl_we;
    logic [AW-1:0]        fl_wa;
    logic signed [FW-1:0] fl_wd;
    logic [AW-1:0]        rd_addr;
    logic                 h_we, e_we, p_we, q_we;
    logic [VB-1:0]        h_wa, e_wa, p_wa, q_wa;
    logic [HW-1:0]        h_wd;
    logic [EXW-1:0]       e_wd;
    logic [NB-1:0]        p_wd;
    logic [VB-1:0]        q_wd;

    // derived values
    logic [NB-1:0]   nv;
    logic [VB-1:0]   src_idx, snk_idx;
    logic [3:0]      in_from, in_to;
    logic [15:0]     in_cap;
    logic            in_ok, cfg_bad;
    logic signed [RW-1:0] resid;
    logic            r_pos;
    logic [EXW-1:0]  r_u, d_ex;
    logic [DW-1:0]   d_new;
    logic [VB-1:0]   cnt_idx, head_inc;
    logic [QSW-1:0]  tail_sum;
    logic [VB-1:0]   tail_idx;
    logic [SW-1:0]   sum_pos;
    logic [XW-1:0]   sum_wide;
    logic [EXW-1:0]  e_a, e_b;
    logic [NB-1:0]   p_a;

    always_comb
    begin
        if (vertex_count_reg < 5'd2)
            nv = NB'(2);
        else if (CW'(vertex_count_reg) > CW'(MAX_VERTICES))
            nv = NB'(MAX_VERTICES);
        else
            nv = NB'(vertex_count_reg);
    end

    assign src_idx  = to_idx(source_reg);
    assign snk_idx  = to_idx(sink_reg);
    assign in_from  = s_axis_tdata[3:0];
    assign in_to    = s_axis_tdata[7:4];
    assign in_cap   = s_axis_tdata[23:8];
    assign in_ok    = (CW'(in_from) < CW'(nv)) && (CW'(in_to) < CW'(nv));
    assign cfg_bad  = (source_reg == sink_reg) || (CW'(source_reg) >= CW'(nv))
                      || (CW'(sink_reg) >= CW'(nv));

    assign resid    = $signed({2'b00, cap_rd_reg}) - RW'(flow_rd_reg);
    assign r_pos    = !resid[RW-1] && (resid != '0);
    assign r_u      = EXW'(resid[DW-1:0]);
    assign d_ex     = (ecur_reg < r_u) ? ecur_reg : r_u;
    assign d_new    = d_ex[DW-1:0];

    assign cnt_idx  = cnt_reg[VB-1:0];
    assign head_inc = (NB'(head_reg) == NB'(MAX_VERTICES - 1)) ? '0 : head_reg + 1'b1;
    assign tail_sum = QSW'(head_reg) + QSW'(qcnt_reg);
    always_comb
    begin
        logic [QSW-1:0] t;
        t = (tail_sum >= QSW'(MAX_VERTICES)) ? tail_sum - QSW'(MAX_VERTICES) : tail_sum;
        tail_idx = t[VB-1:0];
    end

    assign sum_pos  = sum_reg[SW-1] ? '0 : $unsigned(sum_reg);
    assign sum_wide = XW'(sum_pos);

    assign e_a = excess_arr[a_reg];
    assign e_b = excess_arr[b_reg];
    assign p_a = ptr_arr[a_reg];

    assign s_axis_tready = (state_reg == ST_LOAD);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = OUT_TDATA_W'(flow_out_reg);
    assign m_axis_tuser  = err_out_reg;

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        cnt_next      = cnt_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        init_next     = init_reg;
        ecur_next     = ecur_reg;
        hcur_next     = hcur_reg;
        d_next        = d_reg;
        low_next      = low_reg;
        found_next    = found_reg;
        sum_next      = sum_reg;
        head_next     = head_reg;
        qcnt_next     = qcnt_reg;
        flow_out_next = flow_out_reg;
        err_out_next  = err_out_reg;
        cap_we = 1'b0;  cap_wa = '0;  cap_wd = '0;
        fl_we  = 1'b0;  fl_wa  = '0;  fl_wd  = '0;
        rd_addr = '0;
        h_we = 1'b0;  h_wa = '0;  h_wd = '0;
        e_we = 1'b0;  e_wa = '0;  e_wd = '0;
        p_we = 1'b0;  p_wa = '0;  p_wd = '0;
        q_we = 1'b0;  q_wa = '0;  q_wd = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                cap_we   = 1'b1;
                cap_wa   = clr_reg;
                fl_we    = 1'b1;
                fl_wa    = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '1)
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (s_axis_tvalid)
                begin
                    if (in_ok)
                    begin
                        cap_we = 1'b1;
                        cap_wa = {to_idx(in_from), to_idx(in_to)};
                        cap_wd = CAP_BITS'(in_cap);
                    end
                    if (s_axis_tlast)
                    begin
                        if (cfg_bad)
                        begin
                            flow_out_next = '0;
                            err_out_next  = 1'b1;
                            state_next    = ST_OUT;
                        end
                        else
                        begin
                            cnt_next   = '0;
                            head_next  = '0;
                            qcnt_next  = '0;
                            state_next = ST_INIT;
                        end
                    end
                end
            end
            ST_INIT:
            begin
                h_we = 1'b1;  h_wa = cnt_idx;
                e_we = 1'b1;  e_wa = cnt_idx;
                p_we = 1'b1;  p_wa = cnt_idx;
                p_wd = '0;
                if (cnt_idx == src_idx)
                begin
                    h_wd = HW'(nv);
                    e_wd = EXW'(SOURCE_PRELOAD);
                end
                if (cnt_reg == NB'(MAX_VERTICES - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_PRD;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_PRD:
            begin
                if (cnt_reg >= nv)
                    state_next = ST_POP;
                else if (cnt_idx == src_idx)
                    cnt_next = cnt_reg + 1'b1;
                else
                begin
                    a_next     = src_idx;
                    b_next     = cnt_idx;
                    init_next  = 1'b1;
                    ecur_next  = excess_arr[src_idx];
                    rd_addr    = {src_idx, cnt_idx};
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                rd_addr = {b_reg, a_reg};
                if (r_pos && (init_reg || (hcur_reg > height_arr[b_reg])))
                begin
                    fl_we      = 1'b1;
                    fl_wa      = {a_reg, b_reg};
                    fl_wd      = $signed(FW'($unsigned(flow_rd_reg) + d_new));
                    e_we       = 1'b1;
                    e_wa       = a_reg;
                    e_wd       = ecur_reg - EXW'(d_new);
                    d_next     = d_new;
                    state_next = ST_WR2;
                end
                else if (init_reg)
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_PRD;
                end
                else
                begin
                    p_we       = 1'b1;
                    p_wa       = a_reg;
                    p_wd       = p_a + 1'b1;
                    state_next = ST_DCHK;
                end
            end
            ST_WR2:
            begin
                fl_we = 1'b1;
                fl_wa = {b_reg, a_reg};
                fl_wd = $signed(FW'($unsigned(flow_rd_reg) - d_reg));
                e_we  = 1'b1;
                e_wa  = b_reg;
                e_wd  = e_b + EXW'(d_reg);
                if ((e_b == '0) && (qcnt_reg < NB'(MAX_VERTICES)))
                begin
                    q_we      = 1'b1;
                    q_wa      = tail_idx;
                    q_wd      = b_reg;
                    qcnt_next = qcnt_reg + 1'b1;
                end
                if (init_reg)
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_PRD;
                end
                else
                begin
                    p_we       = 1'b1;
                    p_wa       = a_reg;
                    p_wd       = p_a + 1'b1;
                    state_next = ST_DCHK;
                end
            end
            ST_POP:
            begin
                if (qcnt_reg == '0)
                begin
                    cnt_next   = '0;
                    sum_next   = '0;
                    state_next = ST_SRD;
                end
                else
                begin
                    head_next = head_inc;
                    qcnt_next = qcnt_reg - 1'b1;
                    if ((queue_arr[head_reg] != src_idx) && (queue_arr[head_reg] != snk_idx))
                    begin
                        a_next     = queue_arr[head_reg];
                        init_next  = 1'b0;
                        state_next = ST_DCHK;
                    end
                end
            end
            ST_DCHK:
            begin
                if (e_a == '0)
                    state_next = ST_POP;
                else if (p_a < nv)
                begin
                    b_next     = p_a[VB-1:0];
                    ecur_next  = e_a;
                    hcur_next  = height_arr[a_reg];
                    rd_addr    = {a_reg, p_a[VB-1:0]};
                    state_next = ST_EVAL;
                end
                else
                begin
                    cnt_next   = '0;
                    found_next = 1'b0;
                    state_next = ST_LRD;
                end
            end
            ST_LRD:
            begin
                if (cnt_reg < nv)
                begin
                    rd_addr    = {a_reg, cnt_idx};
                    state_next = ST_LEV;
                end
                else
                begin
                    if (found_reg)
                    begin
                        h_we = 1'b1;
                        h_wa = a_reg;
                        h_wd = low_reg + 1'b1;
                    end
                    p_we       = 1'b1;
                    p_wa       = a_reg;
                    p_wd       = '0;
                    state_next = ST_DCHK;
                end
            end
            ST_LEV:
            begin
                if (r_pos && (!found_reg || (height_arr[cnt_idx] < low_reg)))
                begin
                    low_next   = height_arr[cnt_idx];
                    found_next = 1'b1;
                end
                cnt_next   = cnt_reg + 1'b1;
                state_next = ST_LRD;
            end
            ST_SRD:
            begin
                if (cnt_reg < nv)
                begin
                    rd_addr    = {cnt_idx, snk_idx};
                    state_next = ST_SEV;
                end
                else
                begin
                    flow_out_next = sum_wide[FLOW_OUT_W-1:0];
                    err_out_next  = 1'b0;
                    state_next    = ST_OUT;
                end
            end
            ST_SEV:
            begin
                sum_next   = sum_reg + SW'(flow_rd_reg);
                cnt_next   = cnt_reg + 1'b1;
                state_next = ST_SRD;
            end
            ST_OUT:
            begin
                if (m_axis_tready)
                begin
                    clr_next   = '0;
                    state_next = ST_CLEAR;
                end
            end
            default:
                state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cap_we)
            cap_mem[cap_wa] <= cap_wd;
        if (fl_we)
            flow_mem[fl_wa] <= fl_wd;
        cap_rd_reg  <= cap_mem[rd_addr];
        flow_rd_reg <= flow_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (h_we)
            height_arr[h_wa] <= h_wd;
        if (e_we)
            excess_arr[e_wa] <= e_wd;
        if (p_we)
            ptr_arr[p_wa] <= p_wd;
        if (q_we)
            queue_arr[q_wa] <= q_wd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            cnt_reg   <= '0;
            init_reg  <= 1'b0;
            found_reg <= 1'b0;
            head_reg  <= '0;
            qcnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            cnt_reg   <= cnt_next;
            init_reg  <= init_next;
            found_reg <= found_next;
            head_reg  <= head_next;
            qcnt_reg  <= qcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        b_reg        <= b_next;
        ecur_reg     <= ecur_next;
        hcur_reg     <= hcur_next;
        d_reg        <= d_next;
        low_reg      <= low_next;
        sum_reg      <= sum_next;
        flow_out_reg <= flow_out_next;
        err_out_reg  <= err_out_next;
    end

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a result is pending");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        qcnt_reg <= NB'(MAX_VERTICES))
        else $error("active queue overflow");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("error result carries nonzero flow");

    a_last_leaves_load: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("last edge did not start a run");
`endif

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for push_relabel_max_flow_unit. Edge frames go in on
// s_axis from a queue; a built-in FIFO push-relabel predictor gives the flow
// for each frame, and the monitor checks every result on m_axis against it.
// It steps through several vertex/source/sink settings under random idling.
// ----------------------------------------------------------------------------
module tb;
    import prmf_pkg::*;

    typedef struct {
        logic [3:0]  tail;
        logic [3:0]  head;
        logic [15:0] cap;
        logic        last;
    } edge_item_t;

    typedef struct {
        logic [19:0] flow;
        logic        err;
    } flow_result_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata;
    logic s_axis_tlast;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic m_axis_tuser;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    push_relabel_max_flow_unit uut (.*);

    edge_item_t   pending_edges[$];
    flow_result_t expected_flows[$];
    int fail_count = 0;
    int send_idle_pct = 9;
    int recv_idle_pct = 73;
    bit recv_hold = 0;

    // predictor state
    logic [4:0]  cfg_vcount = VERTEX_COUNT_RESET;
    logic [3:0]  cfg_src = SOURCE_RESET;
    logic [3:0]  cfg_snk = SINK_RESET;
    logic [15:0] cap_mat[16][16];
    longint      flow_mat[16][16];
    int          height[16];
    longint      excess[16];
    int          scan_ptr[16];
    int          active_fifo[16];
    int          fifo_head;
    int          fifo_count;

    function automatic int eff_vcount();
        if (cfg_vcount < 2) return 2;
        if (cfg_vcount > 16) return 16;
        return cfg_vcount;
    endfunction

    function automatic void clear_graph();
        for (int i = 0; i < 16; i++)
            for (int j = 0; j < 16; j++)
            begin
                cap_mat[i][j] = '0;
                flow_mat[i][j] = 0;
            end
    endfunction

    function automatic longint resid(int a, int b);
        return longint'(cap_mat[a][b]) - flow_mat[a][b];
    endfunction

    function automatic void push_excess(int a, int b);
        longint r;
        longint d;
        r = resid(a, b);
        d = (excess[a] < r) ? excess[a] : r;
        if (d <= 0) return;
        flow_mat[a][b] += d;
        flow_mat[b][a] -= d;
        excess[a] -= d;
        excess[b] += d;
        if (excess[b] == d && fifo_count < 16)
        begin
            active_fifo[(fifo_head + fifo_count) % 16] = b;
            fifo_count++;
        end
    endfunction

    function automatic void relabel(int a, int nv);
        bit found;
        int low;
        found = 0;
        low = 0;
        for (int i = 0; i < nv; i++)
            if (resid(a, i) > 0 && (!found || height[i] < low))
            begin
                low = height[i];
                found = 1;
            end
        if (found) height[a] = low + 1;
    endfunction

    function automatic logic [19:0] predict_flow(int nv, int s, int t);
        longint total;
        int u;
        total = 0;
        for (int i = 0; i < 16; i++)
        begin
            height[i] = 0;
            excess[i] = 0;
            scan_ptr[i] = 0;
            for (int j = 0; j < 16; j++) flow_mat[i][j] = 0;
        end
        fifo_head = 0;
        fifo_count = 0;
        height[s] = nv;
        excess[s] = SOURCE_PRELOAD;
        for (int i = 0; i < nv; i++)
            if (i != s) push_excess(s, i);
        while (fifo_count > 0)
        begin
            u = active_fifo[fifo_head];
            fifo_head = (fifo_head + 1) % 16;
            fifo_count--;
            if (u != s && u != t)
                while (excess[u] > 0)
                begin
                    if (scan_ptr[u] < nv)
                    begin
                        if (resid(u, scan_ptr[u]) > 0 && height[u] > height[scan_ptr[u]])
                            push_excess(u, scan_ptr[u]);
                        scan_ptr[u]++;
                    end
                    else
                    begin
                        relabel(u, nv);
                        scan_ptr[u] = 0;
                    end
                end
        end
        for (int i = 0; i < nv; i++) total += flow_mat[i][t];
        if (total < 0) total = 0;
        return total[19:0];
    endfunction

    function automatic void load_edge(edge_item_t e);
        int nv;
        flow_result_t res;
        nv = eff_vcount();
        if (e.tail < nv && e.head < nv) cap_mat[e.tail][e.head] = e.cap;
        if (!e.last) return;
        if (cfg_src == cfg_snk || cfg_src >= nv || cfg_snk >= nv)
        begin
            res.flow = '0;
            res.err = 1'b1;
        end
        else
        begin
            res.flow = predict_flow(nv, cfg_src, cfg_snk);
            res.err = 1'b0;
        end
        expected_flows.push_back(res);
        clear_graph();
    endfunction

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        rst_n = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
    end

    initial
    begin
        #100000000;
        $display("Regression FAIL");
        $finish;
    end

    // edge driver
    always @(posedge clk or negedge rst_n)
    begin
        edge_item_t e;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tlast <= 1'b0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (s_axis_tvalid)
            begin
                e.tail = s_axis_tdata[3:0];
                e.head = s_axis_tdata[7:4];
                e.cap = s_axis_tdata[23:8];
                e.last = s_axis_tlast;
                load_edge(e);
            end
            if (pending_edges.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                e = pending_edges.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {e.cap, e.head, e.tail};
                s_axis_tlast <= e.last;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        flow_result_t x;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_flows.size() == 0)
                begin
                    $error("unexpected result flow=%0d err=%0d",
                           m_axis_tdata[19:0], m_axis_tuser);
                    fail_count++;
                end
                else
                begin
                    x = expected_flows.pop_front();
                    if (m_axis_tdata[19:0] !== x.flow)
                    begin
                        $error("total_flow expected %0d actual %0d", x.flow, m_axis_tdata[19:0]);
                        fail_count++;
                    end
                    if (m_axis_tuser !== x.err)
                    begin
                        $error("config_error expected %0d actual %0d", x.err, m_axis_tuser);
                        fail_count++;
                    end
                end
            end
            m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic add_edge(int a, int b, int c, bit l);
        edge_item_t e;
        e.tail = 4'(a);
        e.head = 4'(b);
        e.cap = 16'(c);
        e.last = l;
        pending_edges.push_back(e);
    endtask

    task automatic add_frame(int n);
        int nv;
        int a;
        int b;
        int c;
        int r;
        nv = eff_vcount();
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 85)
            begin
                a = $urandom_range(nv - 1);
                b = $urandom_range(nv - 1);
            end
            else
            begin
                a = $urandom_range(15);
                b = $urandom_range(15);
            end
            r = $urandom_range(99);
            if (r < 50) c = $urandom_range(65535);
            else if (r < 80) c = $urandom_range(15);
            else c = (r < 90) ? 65535 : 0;
            add_edge(a, b, c, i == n - 1);
        end
    endtask

    task automatic wait_idle();
        wait (pending_edges.size() == 0 && !s_axis_tvalid && expected_flows.size() == 0);
        repeat (400) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        forever
        begin
            @(negedge clk);
            if (cfg_ready) break;
        end
        @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_VERTEX_COUNT) cfg_vcount = val;
        else if (idx == CFG_SOURCE) cfg_src = val[3:0];
        else if (idx == CFG_SINK) cfg_snk = val[3:0];
    endtask

    task automatic set_graph(int nv, int s, int t);
        write_reg(CFG_VERTEX_COUNT, 5'(nv));
        write_reg(CFG_SOURCE, {1'($urandom_range(1)), 4'(s)});
        write_reg(CFG_SINK, {1'($urandom_range(1)), 4'(t)});
    endtask

    task automatic random_frames(int items);
        int n;
        int left;
        left = items;
        while (left > 0)
        begin
            n = ($urandom_range(19) == 0) ? 60 : $urandom_range(1, 24);
            if (n > left) n = left;
            add_frame(n);
            left -= n;
        end
    endtask

    initial
    begin
        int vc_set[9] = '{2, 2, 16, 8, 0, 31, 1, 4, 12};
        int src_set[9] = '{0, 1, 15, 3, 0, 5, 1, 7, 11};
        int snk_set[9] = '{1, 0, 0, 5, 1, 14, 1, 1, 2};
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        clear_graph();
        wait (rst_n);
        wait_idle();

        // directed: extremes, overwrite, self loop, zero capacity
        add_edge(0, 1, 65535, 0);
        add_edge(1, 15, 65535, 0);
        add_edge(0, 15, 0, 0);
        add_edge(0, 15, 100, 0);
        add_edge(3, 3, 500, 0);
        add_edge(15, 0, 777, 0);
        add_edge(0, 2, 1, 0);
        add_edge(2, 15, 65535, 0);
        add_edge(5, 6, 0, 1);
        add_edge(0, 15, 65535, 1);
        add_edge(15, 0, 0, 1);
        for (int i = 1; i < 15; i++) add_edge(0, i, 65535, 0);
        for (int i = 1; i < 15; i++) add_edge(i, 15, 65535, i == 14);
        wait_idle();

        set_graph(8, 3, 5);
        add_edge(3, 9, 500, 0);
        add_edge(12, 5, 500, 0);
        add_edge(3, 5, 42, 1);
        wait_idle();
        set_graph(4, 2, 2);
        add_edge(2, 3, 9, 1);
        wait_idle();
        write_reg(2'd3, 5'd31);
        set_graph(4, 7, 1);
        add_edge(0, 1, 9, 1);
        wait_idle();

        for (int p = 0; p < 9; p++)
        begin
            if (p < 3)
            begin
                send_idle_pct = 9;
                recv_idle_pct = 73;
            end
            else if (p < 6)
            begin
                send_idle_pct = 73;
                recv_idle_pct = 9;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            set_graph(vc_set[p], src_set[p], snk_set[p]);
            if (p == 6)
                fork
                    begin
                        recv_hold = 1;
                        repeat (3000) @(posedge clk);
                        recv_hold = 0;
                    end
                join_none
            random_frames(110);
            wait_idle();
        end

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
